>>> src/positional_list_engine_defines.svh
// Assertion macros used by the positional list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define PLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> src/ple_pkg.sv
// Types and codes for the positional list engine.
`default_nettype none
package ple_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_FINAL = 2'd2,
        S_DONE  = 2'd3
    } t_state;

    typedef struct packed {
        t_op                func;
        logic [7:0]         position;
        logic signed [31:0] item_value;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [7:0]         found_position;
        logic signed [31:0] read_value;
        logic [7:0]         entry_count;
    } t_rsp;

endpackage
`default_nettype wire

>>> src/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read ports, read data is registered and lands in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> src/positional_list_engine.sv
// Positional list engine: one ordered list in a RAM, walked one entry per cycle.
// Requests walk the list in S_SCAN, streaming reads and writing entries back;
// insert then writes the new value in S_FINAL. Busy stays high through the strobe cycle.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
`default_nettype none
`include "positional_list_engine_defines.svh"
module positional_list_engine #(
    parameter int CAPACITY = 128
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ple_pkg::t_req i_req,
    output logic               o_done,
    output ple_pkg::t_rsp      o_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 1;
    localparam logic [PW-1:0] CAP_X = PW'(CAPACITY);
    localparam logic [PW-1:0] ONE_X = PW'(1);

    ple_pkg::t_state  r_state, n_state;
    ple_pkg::t_op     r_op, n_op;
    ple_pkg::t_status r_status, n_status;
    logic [7:0]       r_pos, n_pos;
    logic [31:0]      r_val, n_val;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_left, n_left;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_pv, n_pv;
    logic [AW-1:0]    r_pa, n_pa;
    logic [7:0]       r_found, n_found;
    logic [31:0]      r_rd, n_rd;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [31:0]      ram_wdata, ram_rdata;

    logic [PW-1:0]    pos_x, cnt_x, rpos_x, fidx_x;

    assign pos_x  = PW'(i_req.position);
    assign cnt_x  = PW'(r_cnt);
    assign rpos_x = PW'(r_pos);
    assign fidx_x = PW'(r_pa) + ONE_X;

    ple_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::S_IDLE;
            r_cnt   <= '0;
            r_left  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_pv    <= n_pv;
        end
    end

    // Hold the item and result payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_idx    <= n_idx;
        r_pa     <= n_pa;
        r_found  <= n_found;
        r_rd     <= n_rd;
    end

    // Sequence the list walk: decode, stream reads, write back, report
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_status  = r_status;
        n_pos     = r_pos;
        n_val     = r_val;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_idx     = r_idx;
        n_pv      = 1'b0;
        n_pa      = r_idx;
        n_found   = r_found;
        n_rd      = r_rd;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx;

        unique case (r_state)
            ple_pkg::S_IDLE: begin
                if (start) begin
                    n_op     = i_req.func;
                    n_pos    = i_req.position;
                    n_val    = 32'(i_req.item_value);
                    n_status = ple_pkg::ST_OK;
                    n_found  = '0;
                    n_rd     = '0;
                    n_left   = '0;
                    n_state  = ple_pkg::S_DONE;
                    unique case (i_req.func)
                        ple_pkg::OP_INSERT: begin
                            priority if (cnt_x >= CAP_X) begin
                                n_status = ple_pkg::ST_FULL;
                            end else if (pos_x == '0 || pos_x > cnt_x + ONE_X) begin
                                n_status = ple_pkg::ST_BADPOS;
                            end else begin
                                n_idx   = AW'(cnt_x - ONE_X);
                                n_left  = CW'(cnt_x - pos_x + ONE_X);
                                n_cnt   = CW'(cnt_x + ONE_X);
                                n_state = (pos_x == cnt_x + ONE_X) ? ple_pkg::S_FINAL
                                                                   : ple_pkg::S_SCAN;
                            end
                        end
                        ple_pkg::OP_DELETE: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ple_pkg::ST_BADPOS;
                            end else begin
                                n_idx  = AW'(pos_x);
                                n_left = CW'(cnt_x - pos_x);
                                n_cnt  = CW'(cnt_x - ONE_X);
                                if (pos_x != cnt_x) begin
                                    n_state = ple_pkg::S_SCAN;
                                end
                            end
                        end
                        ple_pkg::OP_FIND: begin
                            n_idx    = '0;
                            n_left   = r_cnt;
                            n_status = ple_pkg::ST_NOTFOUND;
                            if (r_cnt != '0) begin
                                n_state = ple_pkg::S_SCAN;
                            end
                        end
                        ple_pkg::OP_READ: begin
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = ple_pkg::ST_BADPOS;
                            end else begin
                                n_idx   = AW'(pos_x - ONE_X);
                                n_left  = CW'(1);
                                n_state = ple_pkg::S_SCAN;
                            end
                        end
                    endcase
                end
            end

            ple_pkg::S_SCAN: begin
                // issue the next read while entries remain
                if (r_left != '0) begin
                    ram_re = 1'b1;
                    n_pv   = 1'b1;
                    n_pa   = r_idx;
                    n_left = r_left - CW'(1);
                    n_idx  = (r_op == ple_pkg::OP_INSERT) ? r_idx - AW'(1)
                                                          : r_idx + AW'(1);
                end
                // consume the entry read last cycle
                if (r_pv) begin
                    unique case (r_op)
                        ple_pkg::OP_INSERT: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pa + AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        ple_pkg::OP_DELETE: begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pa - AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        ple_pkg::OP_FIND: begin
                            if (ram_rdata == r_val) begin
                                n_found  = fidx_x[7:0];
                                n_status = ple_pkg::ST_OK;
                            end
                        end
                        ple_pkg::OP_READ: begin
                            n_rd = ram_rdata;
                        end
                    endcase
                end
                if (r_left == '0) begin
                    n_state = (r_op == ple_pkg::OP_INSERT) ? ple_pkg::S_FINAL
                                                           : ple_pkg::S_DONE;
                end
            end

            ple_pkg::S_FINAL: begin
                // drop the new value into the opened slot
                ram_we    = 1'b1;
                ram_waddr = AW'(rpos_x - ONE_X);
                ram_wdata = r_val;
                n_state   = ple_pkg::S_DONE;
            end

            ple_pkg::S_DONE: begin
                n_state = ple_pkg::S_IDLE;
            end
        endcase
    end

    assign busy                 = (r_state != ple_pkg::S_IDLE);
    assign o_done               = (r_state == ple_pkg::S_DONE);
    assign o_rsp.status         = r_status;
    assign o_rsp.found_position = r_found;
    assign o_rsp.read_value     = $signed(r_rd);
    assign o_rsp.entry_count    = cnt_x[7:0];

    `PLE_ASSERT(a_cnt_in_range, cnt_x <= CAP_X, "entry count beyond capacity")
    `PLE_ASSERT(a_done_pulse, o_done |=> !o_done, "done strobe longer than one cycle")
    `PLE_ASSERT(a_no_rw_clash, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "read and write hit one entry")
    `PLE_ASSERT(a_drain_pending, (r_state == ple_pkg::S_SCAN && r_left == '0) |-> r_pv, "scan ended without a pending read")
    `PLE_ASSERT(a_start_taken, (start && !busy) |=> (busy || !o_done), "item accepted but strobe without busy")

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the positional list engine: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
    import ple_pkg::*;

    localparam int LIST_DEPTH     = 128;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int PHASES         = 4;
    localparam int MAX_GAP        = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP     = 100;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_done;
    t_rsp o_rsp;

    // Hand-written expectation that travels with the item on the ports
    bit   row_typed = 1'b0;
    t_rsp row_rsp   = '0;

    logic signed [31:0] shadow_list [LIST_DEPTH];
    int                 shadow_count = 0;
    t_rsp               awaited_rsp [$];
    t_stim_row          directed_rows [$];
    logic signed [31:0] value_pool [8];

    int fail_count   = 0;
    int quiet_cycles = 0;
    int full_hits    = 0;
    int op_seen [4]     = '{default: 0};
    int status_seen [4] = '{default: 0};

    positional_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the shadow list and return the response it should give
    task automatic apply_list_request(input t_req req, output t_rsp rsp);
        int pos;
        int j;
        int hit;
        rsp = '0;
        rsp.status = ST_OK;
        pos = int'(req.position);
        hit = 0;
        case (req.func)
            OP_INSERT: begin
                if (shadow_count >= LIST_DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (pos < 1 || pos > shadow_count + 1) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    for (j = shadow_count; j >= pos; j--)
                        shadow_list[j] = shadow_list[j - 1];
                    shadow_list[pos - 1] = req.item_value;
                    shadow_count++;
                    if (shadow_count == LIST_DEPTH)
                        full_hits++;
                end
            end
            OP_DELETE: begin
                if (pos < 1 || pos > shadow_count) begin
                    rsp.status = ST_BADPOS;
                end else begin
                    for (j = pos; j < shadow_count; j++)
                        shadow_list[j - 1] = shadow_list[j];
                    shadow_count--;
                end
            end
            OP_FIND: begin
                // keep the last match
                for (j = 0; j < shadow_count; j++)
                    if (shadow_list[j] == req.item_value)
                        hit = j + 1;
                rsp.found_position = hit[7:0];
                if (hit == 0)
                    rsp.status = ST_NOTFOUND;
            end
            default: begin
                if (pos < 1 || pos > shadow_count)
                    rsp.status = ST_BADPOS;
                else
                    rsp.read_value = shadow_list[pos - 1];
            end
        endcase
        rsp.entry_count = shadow_count[7:0];
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    task automatic add_row(input t_op op, input logic [7:0] pos, input logic [31:0] val,
                           input bit typed, input t_status st, input logic [7:0] fpos,
                           input logic [31:0] rval, input logic [7:0] cnt);
        t_stim_row row;
        row.req.func           = op;
        row.req.position       = pos;
        row.req.item_value     = val;
        row.typed              = typed;
        row.rsp.status         = st;
        row.rsp.found_position = fpos;
        row.rsp.read_value     = rval;
        row.rsp.entry_count    = cnt;
        directed_rows.push_back(row);
    endtask

    // Build a random request leaning toward growing or shrinking the list
    function automatic t_req next_request(input bit growing);
        t_req req;
        int   roll;
        int   hi;
        roll = $urandom_range(99);
        if (roll < 80)
            req.func = growing ? OP_INSERT : OP_DELETE;
        else if (roll < 87)
            req.func = growing ? OP_DELETE : OP_INSERT;
        else if (roll < 94)
            req.func = OP_FIND;
        else
            req.func = OP_READ;

        hi = (req.func == OP_INSERT) ? shadow_count + 1 : shadow_count;
        if (hi == 0 || $urandom_range(99) < 12)
            req.position = 8'($urandom_range(255));
        else
            req.position = 8'($urandom_range(hi, 1));

        roll = $urandom_range(99);
        if (req.func == OP_FIND && shadow_count > 0 && roll < 60)
            req.item_value = shadow_list[$urandom_range(shadow_count - 1)];
        else if (roll < 80)
            req.item_value = value_pool[$urandom_range(7)];
        else
            req.item_value = $urandom;
        return req;
    endfunction

    // Present one item after an optional idle gap; return at the falling edge after accept
    task automatic send_item(input t_req req, input bit typed, input t_rsp rsp,
                             input int idle_pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
            gap++;
        end
        i_req     <= req;
        row_typed <= typed;
        row_rsp   <= rsp;
        start     <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the sender off until every outstanding response has come back
    task automatic drain_responses();
        start <= 1'b0;
        @(negedge i_clk);
        while (awaited_rsp.size() != 0)
            @(negedge i_clk);
    endtask

    // Check responses, predict accepted items, watch for a stall
    always @(posedge i_clk) begin
        t_rsp predicted;
        t_rsp want;
        if (i_rst_n) begin
            if (o_done) begin
                status_seen[o_rsp.status]++;
                if (awaited_rsp.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display("%0t: unexpected response, expected none, got %h",
                                 $time, o_rsp);
                end else begin
                    want = awaited_rsp.pop_front();
                    if (o_rsp.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(o_rsp.status));
                    if (o_rsp.found_position !== want.found_position)
                        note_mismatch("found_position", 32'(want.found_position),
                                      32'(o_rsp.found_position));
                    if (o_rsp.read_value !== want.read_value)
                        note_mismatch("read_value", want.read_value, o_rsp.read_value);
                    if (o_rsp.entry_count !== want.entry_count)
                        note_mismatch("entry_count", 32'(want.entry_count),
                                      32'(o_rsp.entry_count));
                end
            end
            if (start && !busy) begin
                apply_list_request(i_req, predicted);
                awaited_rsp.push_back(row_typed ? row_rsp : predicted);
                op_seen[i_req.func]++;
            end
            if (o_done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        t_stim_row row;
        t_req      req;
        bit        growing;
        int        hold;
        int        idle_pct;
        int        per_phase;

        value_pool[0] = 32'sd0;
        value_pool[1] = 32'sd1;
        value_pool[2] = -32'sd1;
        value_pool[3] = 32'h7FFF_FFFF;
        value_pool[4] = 32'h8000_0000;
        value_pool[5] = $urandom;
        value_pool[6] = $urandom;
        value_pool[7] = $urandom;

        // Directed table: empty-list errors, extreme values, duplicates, bad positions
        add_row(OP_READ,   8'd1,   32'd0,          1, ST_BADPOS,   8'd0, 32'd0,          8'd0);
        add_row(OP_FIND,   8'd0,   32'd0,          1, ST_NOTFOUND, 8'd0, 32'd0,          8'd0);
        add_row(OP_DELETE, 8'd1,   32'd0,          1, ST_BADPOS,   8'd0, 32'd0,          8'd0);
        add_row(OP_INSERT, 8'd0,   32'd5,          1, ST_BADPOS,   8'd0, 32'd0,          8'd0);
        add_row(OP_INSERT, 8'd2,   32'd5,          1, ST_BADPOS,   8'd0, 32'd0,          8'd0);
        add_row(OP_INSERT, 8'd1,   32'h7FFF_FFFF,  1, ST_OK,       8'd0, 32'd0,          8'd1);
        add_row(OP_INSERT, 8'd1,   32'h8000_0000,  1, ST_OK,       8'd0, 32'd0,          8'd2);
        add_row(OP_INSERT, 8'd3,   32'hFFFF_FFFF,  1, ST_OK,       8'd0, 32'd0,          8'd3);
        add_row(OP_READ,   8'd1,   32'd0,          1, ST_OK,       8'd0, 32'h8000_0000,  8'd3);
        add_row(OP_READ,   8'd3,   32'd0,          1, ST_OK,       8'd0, 32'hFFFF_FFFF,  8'd3);
        add_row(OP_READ,   8'd255, 32'd0,          1, ST_BADPOS,   8'd0, 32'd0,          8'd3);
        add_row(OP_READ,   8'd0,   32'd0,          1, ST_BADPOS,   8'd0, 32'd0,          8'd3);
        add_row(OP_FIND,   8'd0,   32'h7FFF_FFFF,  1, ST_OK,       8'd2, 32'd0,          8'd3);
        add_row(OP_INSERT, 8'd2,   32'hFFFF_FFFF,  0, ST_OK,       8'd0, 32'd0,          8'd0);
        add_row(OP_FIND,   8'd0,   32'hFFFF_FFFF,  0, ST_OK,       8'd0, 32'd0,          8'd0);
        add_row(OP_FIND,   8'd0,   32'd0,          1, ST_NOTFOUND, 8'd0, 32'd0,          8'd4);
        add_row(OP_INSERT, 8'd5,   32'd0,          0, ST_OK,       8'd0, 32'd0,          8'd0);
        add_row(OP_DELETE, 8'd5,   32'd0,          0, ST_OK,       8'd0, 32'd0,          8'd0);
        add_row(OP_DELETE, 8'd0,   32'd0,          1, ST_BADPOS,   8'd0, 32'd0,          8'd4);
        add_row(OP_DELETE, 8'd255, 32'd0,          1, ST_BADPOS,   8'd0, 32'd0,          8'd4);
        add_row(OP_DELETE, 8'd1,   32'd0,          0, ST_OK,       8'd0, 32'd0,          8'd0);
        add_row(OP_READ,   8'd2,   32'd0,          0, ST_OK,       8'd0, 32'd0,          8'd0);
        add_row(OP_INSERT, 8'd255, 32'd9,          1, ST_BADPOS,   8'd0, 32'd0,          8'd3);

        // Hold reset asserted before releasing it
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_item(row.req, row.typed, row.rsp, 0);
        end

        // Random phases: no gaps, heavy sender gaps, no gaps, light sender gaps
        growing   = 1'b1;
        hold      = 0;
        per_phase = RANDOM_ITEMS / PHASES;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_responses();
            case (phase)
                1:       idle_pct = 77;
                3:       idle_pct = 10;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < per_phase; n++) begin
                // sit full or empty for a while, then reverse direction
                if (growing && shadow_count == LIST_DEPTH) begin
                    hold++;
                    if (hold > 25) begin
                        growing = 1'b0;
                        hold    = 0;
                    end
                end else if (!growing && shadow_count == 0) begin
                    hold++;
                    if (hold > 4) begin
                        growing = 1'b1;
                        hold    = 0;
                    end
                end
                req = next_request(growing);
                send_item(req, 1'b0, '0, idle_pct);
            end
        end

        // Drain, then give the engine time to emit anything stray
        drain_responses();
        repeat (LIST_DEPTH + 8) @(negedge i_clk);

        $display("Covered %0d requests: insert %0d, delete %0d, find %0d, read %0d; list full %0d times.",
                 op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
                 op_seen[OP_INSERT], op_seen[OP_DELETE], op_seen[OP_FIND], op_seen[OP_READ],
                 full_hits);
        $display("Statuses returned: ok %0d, full %0d, bad position %0d, not found %0d; %0d errors.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
                 status_seen[ST_NOTFOUND], fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
